@@ rtl/core/ace_pkg.sv @@
// Shared types and codes for the accelerated encoder with click.
package ace_pkg;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_ROTATE = 3'd1,
    MODE_BUTTON = 3'd2,
    MODE_READ   = 3'd3,
    MODE_CLEAR  = 3'd4
  } ace_mode_t;

  typedef enum logic [2:0] {
    REG_MAX_POSITION = 3'd0,
    REG_SLOW_TICKS   = 3'd1,
    REG_FAST_TICKS   = 3'd2,
    REG_SHORT_CLICK  = 3'd3,
    REG_LONG_CLICK   = 3'd4
  } ace_reg_t;

  localparam logic [1:0] RPT_HELD  = 2'd0;
  localparam logic [1:0] RPT_IDLE  = 2'd1;
  localparam logic [1:0] RPT_SHORT = 2'd2;
  localparam logic [1:0] RPT_LONG  = 2'd3;

  localparam logic [15:0] MAX_POSITION_RESET = 16'd65535;
  localparam logic [11:0] SLOW_TICKS_RESET   = 12'd500;
  localparam logic [11:0] FAST_TICKS_RESET   = 12'd50;
  localparam logic [11:0] SHORT_CLICK_RESET  = 12'd10;
  localparam logic [11:0] LONG_CLICK_RESET   = 12'd100;

  localparam logic [6:0] STEP_SLOW = 7'd1;
  localparam logic [6:0] STEP_MED  = 7'd10;
  localparam logic [6:0] STEP_FAST = 7'd100;

  typedef struct packed {
    logic [2:0] mode;
    logic       pin_level;
  } ace_in_t;

  typedef struct packed {
    logic [15:0] position;
    logic [1:0]  button_report;
  } ace_out_t;

  typedef struct packed {
    logic [15:0] max_position;
    logic [11:0] slow_ticks;
    logic [11:0] fast_ticks;
    logic [11:0] short_click_ticks;
    logic [11:0] long_click_ticks;
  } ace_cfg_t;

endpackage

@@ rtl/core/ace_regs.sv @@
// Configuration register file.
module ace_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output ace_pkg::ace_cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_position      <= ace_pkg::MAX_POSITION_RESET;
      cfg.slow_ticks        <= ace_pkg::SLOW_TICKS_RESET;
      cfg.fast_ticks        <= ace_pkg::FAST_TICKS_RESET;
      cfg.short_click_ticks <= ace_pkg::SHORT_CLICK_RESET;
      cfg.long_click_ticks  <= ace_pkg::LONG_CLICK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ace_pkg::REG_MAX_POSITION: cfg.max_position      <= cfg_data;
        ace_pkg::REG_SLOW_TICKS:   cfg.slow_ticks        <= cfg_data[11:0];
        ace_pkg::REG_FAST_TICKS:   cfg.fast_ticks        <= cfg_data[11:0];
        ace_pkg::REG_SHORT_CLICK:  cfg.short_click_ticks <= cfg_data[11:0];
        ace_pkg::REG_LONG_CLICK:   cfg.long_click_ticks  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/ace_core.sv @@
// Encoder state, timers, click classifier and result word for one event.
module ace_core #(
  parameter int TICK_LIMIT = 4094
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ace_pkg::ace_in_t  in_word,
  input  ace_pkg::ace_cfg_t cfg,
  output ace_pkg::ace_out_t result
);

  localparam int TW = $clog2(TICK_LIMIT + 1);
  localparam int CW = (TW > 12) ? TW : 12;
  localparam logic [TW-1:0] LIMIT = TW'(TICK_LIMIT);

  typedef enum logic [3:0] {
    CS_HELD  = 4'b0001,
    CS_IDLE  = 4'b0010,
    CS_SHORT = 4'b0100,
    CS_LONG  = 4'b1000
  } click_t;

  logic [15:0]   enc_position, enc_position_next;
  logic [TW-1:0] rotation_ticks, rotation_ticks_next;
  logic [TW-1:0] press_ticks, press_ticks_next;
  click_t        click_state, click_state_next;

  logic [CW-1:0] rot_w, press_w;
  logic [6:0]    step;
  logic [15:0]   step16;
  logic          up_ok, down_ok;
  logic [1:0]    state_code;
  logic [1:0]    report;

  assign rot_w   = CW'(rotation_ticks);
  assign press_w = CW'(press_ticks);
  assign step16  = 16'(step);

  always_comb begin
    if (rot_w > CW'(cfg.slow_ticks))
      step = ace_pkg::STEP_SLOW;
    else if (rot_w < CW'(cfg.slow_ticks) && rot_w > CW'(cfg.fast_ticks))
      step = ace_pkg::STEP_MED;
    else if (rot_w < CW'(cfg.fast_ticks) && rot_w > CW'(1))
      step = ace_pkg::STEP_FAST;
    else
      step = '0;
  end

  // step <= max keeps the subtraction from wrapping
  assign up_ok   = (step16 <= cfg.max_position) &&
                   (enc_position <= cfg.max_position - step16);
  assign down_ok = (enc_position >= step16);

  always_comb begin
    case (click_state)
      CS_HELD:  state_code = ace_pkg::RPT_HELD;
      CS_IDLE:  state_code = ace_pkg::RPT_IDLE;
      CS_SHORT: state_code = ace_pkg::RPT_SHORT;
      CS_LONG:  state_code = ace_pkg::RPT_LONG;
      default:  state_code = ace_pkg::RPT_IDLE;
    endcase
  end

  always_comb begin
    enc_position_next   = enc_position;
    rotation_ticks_next = rotation_ticks;
    press_ticks_next    = press_ticks;
    click_state_next    = click_state;
    report              = ace_pkg::RPT_HELD;
    case (in_word.mode)
      ace_pkg::MODE_TICK: begin
        if (rotation_ticks != LIMIT)
          rotation_ticks_next = rotation_ticks + 1'b1;
        if (press_ticks != LIMIT)
          press_ticks_next = press_ticks + 1'b1;
        else if (click_state != CS_HELD)
          press_ticks_next = '0;
      end
      ace_pkg::MODE_ROTATE: begin
        if (!in_word.pin_level) begin
          if (up_ok) begin
            enc_position_next   = enc_position + step16;
            rotation_ticks_next = '0;
          end
        end else if (down_ok) begin
          enc_position_next   = enc_position - step16;
          rotation_ticks_next = '0;
        end
      end
      ace_pkg::MODE_BUTTON: begin
        if (!in_word.pin_level && click_state == CS_IDLE) begin
          press_ticks_next = '0;
          click_state_next = CS_HELD;
        end else if (in_word.pin_level && click_state == CS_HELD) begin
          if (press_w < CW'(cfg.short_click_ticks))
            click_state_next = CS_SHORT;
          else if (press_w > CW'(cfg.long_click_ticks))
            click_state_next = CS_LONG;
        end
      end
      ace_pkg::MODE_READ: begin
        if (click_state != CS_HELD) begin
          report           = state_code;
          click_state_next = CS_IDLE;
        end
      end
      ace_pkg::MODE_CLEAR: enc_position_next = '0;
      default: ;
    endcase
  end

  assign result.position      = enc_position_next;
  assign result.button_report = report;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_position   <= '0;
      rotation_ticks <= '0;
      press_ticks    <= '0;
      click_state    <= CS_IDLE;
    end else if (accept) begin
      enc_position   <= enc_position_next;
      rotation_ticks <= rotation_ticks_next;
      press_ticks    <= press_ticks_next;
      click_state    <= click_state_next;
    end
  end

endmodule

@@ rtl/core/ace_out_buf.sv @@
// Result register with a one-word skid stage.
module ace_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ace_pkg::ace_out_t push_word,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output ace_pkg::ace_out_t out_data
);

  ace_pkg::ace_out_t skid_word;
  logic              skid_valid;
  logic              out_fire;

  assign out_fire = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // no push while the skid holds a word
        if (out_fire) begin
          out_data   <= skid_word;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid || out_fire) begin
          out_data  <= push_word;
          out_valid <= 1'b1;
        end else begin
          skid_word  <= push_word;
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/accelerated_encoder_with_click.sv @@
// Top level: rotary encoder with speed-dependent step and click classification.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid/in_stall   | ace_in_t  (mode, pin_level)
//   out     | output    | out_valid/out_stall | ace_out_t (position, button_report)
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One event per cycle while in_stall is low. State update and result are one
// compare/add pass between the state registers and the result register, or the
// skid when out_stall holds the result register. A one-word skid keeps input open
// while it is empty; in_stall rises only when both result and skid are full.
// rst is synchronous: position and timers clear, click state goes idle,
// registers take their reset values. cfg_ready is always high.
module accelerated_encoder_with_click #(
  parameter int TICK_LIMIT = 4094
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ace_pkg::ace_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ace_pkg::ace_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  ace_pkg::ace_cfg_t cfg;
  ace_pkg::ace_out_t result;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  ace_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ace_core #(
    .TICK_LIMIT (TICK_LIMIT)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_word (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  ace_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall && accept))
    else $error("skid filled without a stalled result");
`endif

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the accelerated encoder with click classification.
module testbench;
  import ace_pkg::*;

  localparam int TICK_LIMIT = 4094;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  ace_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ace_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  accelerated_encoder_with_click #(.TICK_LIMIT(TICK_LIMIT)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encoder state and register copies
  logic [15:0] lim_max;
  logic [11:0] lim_slow, lim_fast, lim_short, lim_long;
  logic [15:0] enc_pos;
  logic [11:0] rot_ticks, press_cnt;
  logic [1:0]  click;

  ace_out_t position_report_q[$];
  int mismatches = 0;
  int words_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  task automatic reset_encoder_model();
    lim_max   = MAX_POSITION_RESET;
    lim_slow  = SLOW_TICKS_RESET;
    lim_fast  = FAST_TICKS_RESET;
    lim_short = SHORT_CLICK_RESET;
    lim_long  = LONG_CLICK_RESET;
    enc_pos   = '0;
    rot_ticks = '0;
    press_cnt = '0;
    click     = RPT_IDLE;
  endtask

  // Applies one accepted word to the state copy and queues the position/report it yields.
  task automatic advance_encoder(input ace_in_t w);
    int unsigned step;
    ace_out_t res;
    res.button_report = RPT_HELD;
    step = 0;
    case (w.mode)
      MODE_TICK: begin
        if (rot_ticks < TICK_LIMIT) rot_ticks = rot_ticks + 1'b1;
        if (press_cnt < TICK_LIMIT) press_cnt = press_cnt + 1'b1;
        else press_cnt = (click == RPT_HELD) ? 12'(TICK_LIMIT) : 12'd0;
      end
      MODE_ROTATE: begin
        if (rot_ticks > lim_slow) step = STEP_SLOW;
        else if (rot_ticks < lim_slow && rot_ticks > lim_fast) step = STEP_MED;
        else if (rot_ticks < lim_fast && rot_ticks > 1) step = STEP_FAST;
        if (!w.pin_level) begin
          if (step <= lim_max && enc_pos <= lim_max - step) begin
            enc_pos = enc_pos + step[15:0];
            rot_ticks = '0;
          end
        end else if (enc_pos >= step) begin
          enc_pos = enc_pos - step[15:0];
          rot_ticks = '0;
        end
      end
      MODE_BUTTON: begin
        if (!w.pin_level && click == RPT_IDLE) begin
          press_cnt = '0;
          click = RPT_HELD;
        end else if (w.pin_level && click == RPT_HELD) begin
          if (press_cnt < lim_short) click = RPT_SHORT;
          else if (press_cnt > lim_long) click = RPT_LONG;
        end
      end
      MODE_READ: begin
        if (click != RPT_HELD) begin
          res.button_report = click;
          click = RPT_IDLE;
        end
      end
      MODE_CLEAR: enc_pos = '0;
      default: ;
    endcase
    res.position = enc_pos;
    position_report_q.push_back(res);
  endtask

  function automatic int pick_idle(input int pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  task automatic send_event(input logic [2:0] mode, input logic pin);
    ace_in_t w;
    int gap;
    w.mode = mode;
    w.pin_level = pin;
    gap = pick_idle(gap_pct);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_encoder(w);
    words_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_event(MODE_TICK, 1'($urandom_range(0, 1)));
  endtask

  // Stop sending and wait until every queued result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (position_report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input ace_reg_t idx, input logic [15:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MAX_POSITION: lim_max   = val;
      REG_SLOW_TICKS:   lim_slow  = val[11:0];
      REG_FAST_TICKS:   lim_fast  = val[11:0];
      REG_SHORT_CLICK:  lim_short = val[11:0];
      REG_LONG_CLICK:   lim_long  = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int mx, input int slow, input int fast,
                            input int shrt, input int lng);
    write_reg(REG_MAX_POSITION, 16'(mx));
    write_reg(REG_SLOW_TICKS,   16'(slow));
    write_reg(REG_FAST_TICKS,   16'(fast));
    write_reg(REG_SHORT_CLICK,  16'(shrt));
    write_reg(REG_LONG_CLICK,   16'(lng));
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // result sink: random stall, mostly short runs
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    ace_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (position_report_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word position=%0d report=%0d",
                                out_data.position, out_data.button_report));
      end else begin
        want = position_report_q.pop_front();
        if (out_data.position !== want.position)
          flag_mismatch($sformatf("position expected %0d got %0d",
                                  want.position, out_data.position));
        if (out_data.button_report !== want.button_report)
          flag_mismatch($sformatf("button_report expected %0d got %0d",
                                  want.button_report, out_data.button_report));
      end
    end
  end

  // reset values in force: basic moves, click, clear and spare modes
  task automatic test_directed();
    send_event(MODE_READ, 1'b0);
    send_event(MODE_ROTATE, 1'b0);
    send_ticks(2);
    send_event(MODE_ROTATE, 1'b0);
    send_event(MODE_ROTATE, 1'b0);
    send_ticks(2);
    send_event(MODE_ROTATE, 1'b1);
    send_ticks(2);
    send_event(MODE_ROTATE, 1'b1);   // refused below zero
    send_ticks(1);
    send_event(MODE_ROTATE, 1'b0);
    send_event(MODE_BUTTON, 1'b0);
    send_event(MODE_READ, 1'b0);
    send_event(MODE_BUTTON, 1'b0);   // press while held: ignored
    send_event(MODE_BUTTON, 1'b1);
    send_event(MODE_READ, 1'b1);
    send_event(MODE_READ, 1'b0);
    send_event(MODE_BUTTON, 1'b1);   // release while idle: ignored
    send_event(MODE_CLEAR, 1'b1);
    for (int m = MODE_CLEAR + 1; m < 8; m++) begin
      send_event(3'(m), 1'(m));
    end
  endtask

  task automatic test_step_select();
    set_config(205, 6, 3, 4, 9);
    for (int n = 0; n < 9; n++) begin
      send_ticks(n);
      send_event(MODE_ROTATE, 1'b0);
    end
    for (int n = 0; n < 9; n++) begin
      send_ticks(n);
      send_event(MODE_ROTATE, 1'(n % 3 != 0));
    end
    // position above a lowered bound: only down moves get through
    set_config(0, 0, 0, 0, 4094);
    for (int n = 0; n < 4; n++) begin
      send_ticks(n);
      send_event(MODE_ROTATE, 1'b0);
      send_event(MODE_ROTATE, 1'b1);
    end
  endtask

  task automatic test_click_classes();
    set_config(65535, 500, 50, 3, 6);
    for (int k = 0; k < 10; k++) begin
      send_event(MODE_BUTTON, 1'b0);
      send_ticks(k);
      send_event(MODE_BUTTON, 1'b1);
      send_event(MODE_READ, 1'b0);
      send_event(MODE_BUTTON, 1'b0);
      if (click == RPT_HELD) begin
        send_ticks(4);
        send_event(MODE_BUTTON, 1'b1);
      end
      send_event(MODE_READ, 1'b0);
      send_event(MODE_READ, 1'b0);
    end
    set_config(65535, 500, 50, 0, 0);
    send_event(MODE_BUTTON, 1'b0);
    send_event(MODE_BUTTON, 1'b1);
    send_event(MODE_READ, 1'b0);
    send_ticks(1);
    send_event(MODE_BUTTON, 1'b1);
    send_event(MODE_READ, 1'b0);
  endtask

  task automatic test_timer_limits();
    gap_pct = 0;
    stall_pct = 5;
    set_config(65535, 4094, 2, 0, 4094);
    send_event(MODE_BUTTON, 1'b0);
    send_ticks(TICK_LIMIT + 6);
    send_event(MODE_ROTATE, 1'b1);   // saturated timer equal to slow: step zero
    send_event(MODE_BUTTON, 1'b1);   // held count equals long: stays held
    send_event(MODE_READ, 1'b0);
    write_reg(REG_LONG_CLICK, 16'd4093);
    send_event(MODE_BUTTON, 1'b1);
    send_event(MODE_READ, 1'b0);
    send_ticks(3);                   // idle press timer wraps
    send_event(MODE_BUTTON, 1'b0);
    send_event(MODE_BUTTON, 1'b1);
    send_event(MODE_READ, 1'b0);
    write_reg(REG_SLOW_TICKS, 16'd3);
    send_ticks(4);
    send_event(MODE_ROTATE, 1'b0);   // above slow: step one
    send_ticks(1);
    send_event(MODE_ROTATE, 1'b0);
  endtask

  function automatic int burst_len(input int hi);
    if (hi > 60) hi = 60;
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(0, hi);
  endfunction

  task automatic random_sequence();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      send_ticks(burst_len(int'(lim_slow) + 3));
      n = $urandom_range(1, 3);
      repeat (n) send_event(MODE_ROTATE, 1'($urandom_range(0, 9) < 4));
    end else if (kind <= 6) begin
      send_event(MODE_BUTTON, 1'b0);
      send_ticks(burst_len(int'(lim_long) + 4));
      send_event(MODE_BUTTON, 1'b1);
      if ($urandom_range(0, 9) < 7) send_event(MODE_READ, 1'($urandom_range(0, 1)));
    end else if (kind == 7) begin
      send_event(MODE_READ, 1'($urandom_range(0, 1)));
    end else if (kind == 8) begin
      if ($urandom_range(0, 1)) send_event(MODE_CLEAR, 1'($urandom_range(0, 1)));
      else send_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end else begin
      // broken click sequences
      n = $urandom_range(1, 4);
      repeat (n) send_event(MODE_BUTTON, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_phase(input int budget, input bit pause_midway);
    int start;
    bit paused;
    start = words_sent;
    paused = 1'b0;
    while (words_sent - start < budget) begin
      random_sequence();
      if (pause_midway && !paused && words_sent - start >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  task automatic random_small_config();
    int mx;
    int slow;
    int shrt;
    case ($urandom_range(0, 3))
      0: mx = $urandom_range(0, 5);
      1: mx = $urandom_range(100, 400);
      2: mx = 65535;
      default: mx = $urandom_range(0, 65535);
    endcase
    slow = $urandom_range(0, 40);
    shrt = $urandom_range(0, 15);
    set_config(mx, slow, $urandom_range(0, slow + 2), shrt, $urandom_range(0, 30));
  endtask

  task automatic test_random();
    gap_pct = 30;
    stall_pct = 30;
    random_small_config();
    random_phase(140, 1'b1);
    gap_pct = 0;
    stall_pct = 0;
    random_small_config();
    random_phase(130, 1'b0);
    gap_pct = 20;
    stall_pct = 40;
    set_config(65535, 4094, 0, 0, 4094);
    random_phase(120, 1'b0);
    set_config(0, 8, 2, 3, 7);
    random_phase(120, 1'b0);
    gap_pct = 50;
    stall_pct = 15;
    random_small_config();
    random_phase(150, 1'b0);
    gap_pct = 10;
    stall_pct = 10;
    set_config(65535, 500, 50, 10, 100);
    random_phase(140, 1'b0);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_encoder_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_step_select();
    test_click_classes();
    test_timer_limits();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && position_report_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
